>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, switched off during reset.
`define SPIMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on the rising clock edge, also during reset.
`define SPIMF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/spimf_pkg.sv
// ----------------------------------------------------------------------------
// spimf_pkg
// Types and constants of the SPI master with transmit and receive FIFOs.
// ----------------------------------------------------------------------------
package spimf_pkg;

	localparam int unsigned DEF_FIFO_DEPTH   = 128;
	localparam int unsigned DEF_SELECT_COUNT = 4;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned SEL_W   = 4;
	localparam int unsigned CTRL_W  = 15;
	localparam int unsigned MASK_W  = 7;
	localparam int unsigned BYTE_W  = 8;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	localparam logic [3:0] REG_CTRL   = 4'd0;
	localparam logic [3:0] REG_STATUS = 4'd1;
	localparam logic [3:0] REG_IER    = 4'd2;
	localparam logic [3:0] REG_IDR    = 4'd3;
	localparam logic [3:0] REG_IMR    = 4'd4;
	localparam logic [3:0] REG_ENABLE = 4'd5;
	localparam logic [3:0] REG_TXD    = 4'd7;
	localparam logic [3:0] REG_RXD    = 4'd8;

	// Control register fields.
	localparam int unsigned CTRL_CPOL = 1;
	localparam int unsigned CTRL_CPHA = 2;
	localparam int unsigned CTRL_DIV  = 3;
	localparam int unsigned CTRL_SEL  = 10;

endpackage

>>> rtl/core/spimf_in_if.sv
// ----------------------------------------------------------------------------
// spimf_in_if
// Request channel: one register access or reference clock tick per request.
// ----------------------------------------------------------------------------
interface spimf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  reg_index;
	logic [31:0] write_data;
	logic        miso;

	modport source (output valid, mode, reg_index, write_data, miso, input ready);
	modport sink (input valid, mode, reg_index, write_data, miso, output ready);
endinterface

>>> rtl/core/spimf_out_if.sv
// ----------------------------------------------------------------------------
// spimf_out_if
// Result channel: read data and line levels after each request.
// ----------------------------------------------------------------------------
interface spimf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        sclk;
	logic        mosi;
	logic [3:0]  select_lines;
	logic        irq;

	modport source (output valid, read_data, sclk, mosi, select_lines, irq, input ready);
	modport sink (input valid, read_data, sclk, mosi, select_lines, irq, output ready);
endinterface

>>> rtl/core/spimf_ram.sv
// ----------------------------------------------------------------------------
// spimf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spimf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/core/spi_master_with_fifos_core.sv
// ----------------------------------------------------------------------------
// spi_master_with_fifos_core
// SPI master with byte FIFOs for transmit and receive behind word registers.
// ----------------------------------------------------------------------------
// Each request is a register write, a register read or one reference clock
// tick. A request is taken every cycle while results are accepted. Its result
// is presented from the result register after passing the request register:
// the FIFO memory read is issued together with the load of the request
// register, and the work is done between that register and the result
// register. While a result waits, one more request is taken into the request
// register, and then the input stalls until the waiting result is accepted.
module spi_master_with_fifos_core
	import spimf_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH   = DEF_FIFO_DEPTH,
	parameter int unsigned SELECT_COUNT = DEF_SELECT_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	spimf_in_if.sink  in_ch,
	spimf_out_if.source out_ch
);
	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned LW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [LW-1:0] FULL = LW'(FIFO_DEPTH);

	// Control state.
	logic [CTRL_W-1:0] ctrl_q, ctrl_d;
	logic              ovf_q, ovf_d;
	logic [MASK_W-1:0] mask_q, mask_d;
	logic              en_q, en_d;
	logic [PW-1:0]     tx_rp_q, tx_rp_d, tx_wp_q, tx_wp_d;
	logic [PW-1:0]     rx_rp_q, rx_rp_d, rx_wp_q, rx_wp_d;
	logic [LW-1:0]     tx_lvl_q, tx_lvl_d, rx_lvl_q, rx_lvl_d;
	logic [BYTE_W-1:0] tx_sr_q, tx_sr_d, rx_sr_q, rx_sr_d;
	logic [3:0]        bcnt_q, bcnt_d;
	logic [7:0]        tdiv_q, tdiv_d;
	logic              act_q, act_d;

	// Request stage.
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [3:0]        idx_s1;
	logic [DATA_W-1:0] wd_s1;
	logic              miso_s1;
	logic              txbyp_v_s1, rxbyp_v_s1;
	logic [BYTE_W-1:0] txbyp_s1, rxbyp_s1;

	// Result stage.
	logic              valid_s2;
	logic [DATA_W-1:0] rd_s2;
	logic              sclk_s2, mosi_s2, irq_s2;
	logic [SEL_W-1:0]  sel_s2;

	logic accept, advance, commit;
	logic              tx_we, rx_we;
	logic [PW-1:0]     tx_raddr, rx_raddr;
	logic [BYTE_W-1:0] tx_rdata, rx_rdata, tx_byte, rx_byte, rx_wdata;
	logic [DATA_W-1:0] rd_d;
	logic              sclk_d, mosi_d, irq_d;
	logic [SEL_W-1:0]  sel_d;
	logic [MASK_W-1:0] stat_d;
	logic [8:0]        half;
	logic [7:0]        tdiv_inc;
	logic              cpha;

	assign advance     = !valid_s2 || out_ch.ready;
	assign commit      = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	// The memory read for a request is issued as it is taken, at the pointer
	// that the request ahead of it leaves behind.
	assign tx_raddr = commit ? tx_rp_d : tx_rp_q;
	assign rx_raddr = commit ? rx_rp_d : rx_rp_q;
	assign tx_byte  = txbyp_v_s1 ? txbyp_s1 : tx_rdata;
	assign rx_byte  = rxbyp_v_s1 ? rxbyp_s1 : rx_rdata;
	assign cpha     = ctrl_q[CTRL_CPHA];
	assign half     = 9'd1 << ctrl_q[CTRL_DIV +: 3];
	assign tdiv_inc = tdiv_q + 8'd1;

	spimf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_wp_q),
		.wdata (wd_s1[BYTE_W-1:0]),
		.re    (accept),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	spimf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wp_q),
		.wdata (rx_wdata),
		.re    (accept),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	always_comb begin
		ctrl_d   = ctrl_q;
		ovf_d    = ovf_q;
		mask_d   = mask_q;
		en_d     = en_q;
		tx_rp_d  = tx_rp_q;
		tx_wp_d  = tx_wp_q;
		rx_rp_d  = rx_rp_q;
		rx_wp_d  = rx_wp_q;
		tx_lvl_d = tx_lvl_q;
		rx_lvl_d = rx_lvl_q;
		tx_sr_d  = tx_sr_q;
		rx_sr_d  = rx_sr_q;
		bcnt_d   = bcnt_q;
		tdiv_d   = tdiv_q;
		act_d    = act_q;
		tx_we    = 1'b0;
		rx_we    = 1'b0;
		rx_wdata = rx_sr_q;
		rd_d     = '0;
		if (commit) begin
			unique case (mode_s1)
				MODE_WRITE: begin
					unique case (idx_s1)
						REG_CTRL: ctrl_d = wd_s1[CTRL_W-1:0];
						REG_STATUS: if (wd_s1[0]) ovf_d = 1'b0;
						REG_IER: mask_d = mask_q | wd_s1[MASK_W-1:0];
						REG_IDR: mask_d = mask_q & ~wd_s1[MASK_W-1:0];
						REG_ENABLE: begin
							en_d = wd_s1[0];
							if (!wd_s1[0]) begin
								act_d   = 1'b0;
								bcnt_d  = '0;
								tdiv_d  = '0;
								tx_sr_d = '0;
								rx_sr_d = '0;
							end
						end
						REG_TXD: begin
							if (tx_lvl_q != FULL) begin
								tx_we    = 1'b1;
								tx_wp_d  = (tx_wp_q == LAST) ? '0 : tx_wp_q + 1'b1;
								tx_lvl_d = tx_lvl_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
				MODE_READ: begin
					unique case (idx_s1)
						REG_CTRL: rd_d = DATA_W'(ctrl_q);
						REG_STATUS: rd_d = {26'd0, rx_lvl_q == FULL, rx_lvl_q != '0,
							tx_lvl_q == FULL, tx_lvl_q == '0, 1'b0, ovf_q};
						REG_IMR: rd_d = DATA_W'(mask_q);
						REG_ENABLE: rd_d = DATA_W'(en_q);
						REG_RXD: begin
							if (rx_lvl_q != '0) begin
								rd_d     = DATA_W'(rx_byte);
								rx_rp_d  = (rx_rp_q == LAST) ? '0 : rx_rp_q + 1'b1;
								rx_lvl_d = rx_lvl_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				MODE_TICK: begin
					if (en_q) begin
						if (!act_q) begin
							if (tx_lvl_q != '0) begin
								tx_sr_d  = tx_byte;
								rx_sr_d  = '0;
								tx_rp_d  = (tx_rp_q == LAST) ? '0 : tx_rp_q + 1'b1;
								tx_lvl_d = tx_lvl_q - 1'b1;
								act_d    = 1'b1;
								bcnt_d   = '0;
								tdiv_d   = '0;
							end
						end else if ({1'b0, tdiv_inc} < half) begin
							tdiv_d = tdiv_inc;
						end else begin
							tdiv_d = '0;
							// Even edges lead; CPHA moves sampling to the trailing edge.
							if (!bcnt_q[0] ^ cpha) begin
								rx_sr_d = {rx_sr_q[BYTE_W-2:0], miso_s1};
							end else if (!(cpha && bcnt_q == '0)) begin
								tx_sr_d = {tx_sr_q[BYTE_W-2:0], 1'b0};
							end
							if (bcnt_q == 4'd15) begin
								rx_wdata = rx_sr_d;
								if (rx_lvl_q == FULL) begin
									ovf_d = 1'b1;
								end else begin
									rx_we    = 1'b1;
									rx_wp_d  = (rx_wp_q == LAST) ? '0 : rx_wp_q + 1'b1;
									rx_lvl_d = rx_lvl_q + 1'b1;
								end
								act_d   = 1'b0;
								bcnt_d  = '0;
								tx_sr_d = '0;
								rx_sr_d = '0;
							end else begin
								bcnt_d = bcnt_q + 4'd1;
							end
						end
					end
				end
				MODE_NOP: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		sclk_d = ctrl_d[CTRL_CPOL] ^ (act_d & bcnt_d[0]);
		mosi_d = act_d & tx_sr_d[BYTE_W-1];
		for (int i = 0; i < SEL_W; i++) begin
			sel_d[i] = (i < SELECT_COUNT) ? ctrl_d[CTRL_SEL + i] : 1'b1;
		end
		stat_d = {1'b0, rx_lvl_d == FULL, rx_lvl_d != '0, tx_lvl_d == FULL,
			tx_lvl_d == '0, 1'b0, ovf_d};
		irq_d  = |(stat_d & mask_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			ovf_q    <= 1'b0;
			mask_q   <= '0;
			en_q     <= 1'b0;
			tx_rp_q  <= '0;
			tx_wp_q  <= '0;
			rx_rp_q  <= '0;
			rx_wp_q  <= '0;
			tx_lvl_q <= '0;
			rx_lvl_q <= '0;
			tx_sr_q  <= '0;
			rx_sr_q  <= '0;
			bcnt_q   <= '0;
			tdiv_q   <= '0;
			act_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			ctrl_q   <= ctrl_d;
			ovf_q    <= ovf_d;
			mask_q   <= mask_d;
			en_q     <= en_d;
			tx_rp_q  <= tx_rp_d;
			tx_wp_q  <= tx_wp_d;
			rx_rp_q  <= rx_rp_d;
			rx_wp_q  <= rx_wp_d;
			tx_lvl_q <= tx_lvl_d;
			rx_lvl_q <= rx_lvl_d;
			tx_sr_q  <= tx_sr_d;
			rx_sr_q  <= rx_sr_d;
			bcnt_q   <= bcnt_d;
			tdiv_q   <= tdiv_d;
			act_q    <= act_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// A write landing on the address being read returns the old word, so the
	// new byte is forwarded alongside the request.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= in_ch.mode;
			idx_s1     <= in_ch.reg_index;
			wd_s1      <= in_ch.write_data;
			miso_s1    <= in_ch.miso;
			txbyp_v_s1 <= tx_we && (tx_wp_q == tx_raddr);
			txbyp_s1   <= wd_s1[BYTE_W-1:0];
			rxbyp_v_s1 <= rx_we && (rx_wp_q == rx_raddr);
			rxbyp_s1   <= rx_wdata;
		end
		if (commit) begin
			rd_s2   <= rd_d;
			sclk_s2 <= sclk_d;
			mosi_s2 <= mosi_d;
			sel_s2  <= sel_d;
			irq_s2  <= irq_d;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.read_data    = rd_s2;
	assign out_ch.sclk         = sclk_s2;
	assign out_ch.mosi         = mosi_s2;
	assign out_ch.select_lines = sel_s2;
	assign out_ch.irq          = irq_s2;
endmodule

>>> rtl/core/spimf_checker.sv
// ----------------------------------------------------------------------------
// spimf_checker
// Port-level checks of the SPI master core, attached to it by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spimf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic        sclk,
	input logic        mosi
);
	`SPIMF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`SPIMF_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(read_data) && $stable(sclk) && $stable(mosi), "stalled result changed")
	`SPIMF_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "requests refused without a waiting result")
	`SPIMF_ASSERT(a_read_width, out_valid |-> read_data[31:15] == 17'd0, "read data wider than any register")
	`SPIMF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")
endmodule

bind spi_master_with_fifos_core spimf_checker u_spimf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.read_data (out_ch.read_data),
	.sclk      (out_ch.sclk),
	.mosi      (out_ch.mosi)
);
